FILE: rtl/van_genuchten_water_content_unit_assert.svh
// Assertion macros for the van Genuchten water content unit.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef VAN_GENUCHTEN_WATER_CONTENT_UNIT_ASSERT_SVH
`define VAN_GENUCHTEN_WATER_CONTENT_UNIT_ASSERT_SVH

// same-cycle implication
`define VGW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define VGW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/vgw_pkg.sv
// Package for the van Genuchten water content unit: widths, stage counts,
// constants and register indexes. No dependencies.
`default_nettype none

package vgw_pkg;

  localparam int HEAD_BITS  = 32;
  localparam int FRAC       = 30;
  localparam int ALPHA_W    = 24;
  localparam int N_W        = 20;
  localparam int M_W        = 17;
  localparam int CONT_W     = 16;
  localparam int RND_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int LOG_IN_W  = (HEAD_BITS > 32) ? HEAD_BITS : 32;
  localparam int LOG_K_W   = $clog2(LOG_IN_W);
  localparam int LOG_RES_W = LOG_K_W + FRAC;
  localparam int LOG_LAT   = FRAC + 1;

  localparam int LX_W    = LOG_RES_W + 2;
  localparam int AL_W    = LOG_RES_W + 1;
  localparam int AL_LO_W = AL_W / 2;
  localparam int AL_HI_W = AL_W - AL_LO_W;
  localparam int AY_W    = N_W + AL_W - RND_W;
  localparam int T_W     = AY_W + 1;
  localparam int T_LO_W  = T_W / 2;
  localparam int T_HI_W  = T_W - T_LO_W;
  localparam int E_W     = M_W + T_W - RND_W;

  localparam int EXP_IN_W   = E_W;
  localparam int AI_W       = EXP_IN_W - FRAC;
  localparam int Q_W        = FRAC + 1;
  localparam int P_W        = FRAC + 3;
  localparam int U_W        = FRAC - 8;
  localparam int U2_W       = 2 * U_W - FRAC;
  localparam int U3_W       = U2_W + U_W - FRAC;
  localparam int D6_MUL_W   = 6;
  localparam int D6_SHIFT   = 8;
  localparam int D6_W       = U3_W + D6_MUL_W - D6_SHIFT;
  localparam int SQ_STEPS   = 8;
  localparam int EXP_LAT    = SQ_STEPS + 5;
  localparam int SH_W       = 6;
  localparam int EXP_KILL_AI = 61;

  localparam int MIX_W    = CONT_W + Q_W;
  localparam int PIPE_LAT = 1 + LOG_LAT + 3 + EXP_LAT + LOG_LAT + 3 + EXP_LAT + 2;
  localparam int BYP_LEN  = PIPE_LAT - 3;
  localparam int AY_LEN   = EXP_LAT + LOG_LAT;

  localparam logic [FRAC-1:0]     LN2_Q30  = 30'd744261118;
  localparam logic [D6_MUL_W-1:0] DIV6_MUL = 6'd43;
  localparam logic [Q_W-1:0]      ONE_Q    = {1'b1, {FRAC{1'b0}}};
  localparam logic [LX_W-1:0]     LX_OFS   = LX_W'(2 * RND_W) << FRAC;
  localparam logic [LOG_RES_W-1:0] LOG_OFS = LOG_RES_W'(FRAC) << FRAC;
  localparam logic [CONT_W-1:0]   WC_MAX   = {CONT_W{1'b1}};

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 24'd65536;
  localparam logic [N_W-1:0]     N_RST     = 20'd65536;
  localparam logic [M_W-1:0]     M_RST     = 17'd65536;
  localparam logic [CONT_W-1:0]  SAT_RST   = 16'd65535;
  localparam logic [CONT_W-1:0]  RES_RST   = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 3'd0,
    CFG_SHAPE_N = 3'd1,
    CFG_SHAPE_M = 3'd2,
    CFG_SAT = 3'd3,
    CFG_RES = 3'd4
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/vgw_log2.sv
// Pipelined log2 of an unsigned integer, result in Q.30, one bit per stage.
// Depends on vgw_pkg.
`default_nettype none

module vgw_log2 (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [vgw_pkg::LOG_IN_W-1:0]  v_in,
  output logic      [vgw_pkg::LOG_RES_W-1:0] res_out
);

  logic [vgw_pkg::Q_W-1:0]       mant_r   [0:vgw_pkg::FRAC];
  logic [vgw_pkg::Q_W-1:0]       mant_nxt [0:vgw_pkg::FRAC];
  logic [vgw_pkg::LOG_RES_W-1:0] res_r    [0:vgw_pkg::FRAC];
  logic [vgw_pkg::LOG_RES_W-1:0] res_nxt  [0:vgw_pkg::FRAC];
  logic [2*vgw_pkg::Q_W-1:0]     sq_w     [1:vgw_pkg::FRAC];
  logic [vgw_pkg::Q_W:0]         sq_s     [1:vgw_pkg::FRAC];
  logic [vgw_pkg::LOG_K_W-1:0]   k;
  logic [vgw_pkg::LOG_K_W-1:0]   shamt;
  logic [vgw_pkg::LOG_IN_W-1:0]  norm;

  always_comb begin
    k = '0;
    for (int i = 0; i < vgw_pkg::LOG_IN_W; i++) begin
      if (v_in[i]) k = vgw_pkg::LOG_K_W'(i);
    end
    shamt = vgw_pkg::LOG_K_W'(vgw_pkg::LOG_IN_W - 1) - k;
    norm = v_in << shamt;
    mant_nxt[0] = norm[vgw_pkg::LOG_IN_W-1 -: vgw_pkg::Q_W];
    res_nxt[0] = {k, {vgw_pkg::FRAC{1'b0}}};
    for (int i = 1; i <= vgw_pkg::FRAC; i++) begin
      sq_w[i] = mant_r[i-1] * mant_r[i-1];
      sq_s[i] = sq_w[i][2*vgw_pkg::Q_W-1:vgw_pkg::FRAC];
      res_nxt[i] = res_r[i-1];
      if (sq_s[i][vgw_pkg::Q_W]) begin
        mant_nxt[i] = sq_s[i][vgw_pkg::Q_W:1];
        res_nxt[i][vgw_pkg::FRAC-i] = 1'b1;
      end else begin
        mant_nxt[i] = sq_s[i][vgw_pkg::Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= vgw_pkg::FRAC; i++) begin
        mant_r[i] <= mant_nxt[i];
        res_r[i] <= res_nxt[i];
      end
    end
  end

  assign res_out = res_r[vgw_pkg::FRAC];

endmodule

`default_nettype wire

FILE: rtl/vgw_exp2neg.sv
// Pipelined 2^-a for a in Q.30: Taylor series, eight squarings, final shift.
// Depends on vgw_pkg.
`default_nettype none

module vgw_exp2neg (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [vgw_pkg::EXP_IN_W-1:0]  a_in,
  output logic      [vgw_pkg::Q_W-1:0]       q_out
);

  typedef struct packed {
    logic                     kill;
    logic                     use_one;
    logic [vgw_pkg::SH_W-1:0] sh;
  } exp_ctrl_t;

  exp_ctrl_t                       ctrl_nxt;
  exp_ctrl_t                       ctrl_r [0:vgw_pkg::EXP_LAT-2];
  logic [vgw_pkg::AI_W-1:0]        ai;
  logic [vgw_pkg::FRAC-1:0]        af;
  logic [vgw_pkg::FRAC-1:0]        fr;
  logic [2*vgw_pkg::FRAC-1:0]      fprod;
  logic [vgw_pkg::U_W-1:0]         u1_r, u2_u_r, u3_u_r;
  logic [2*vgw_pkg::U_W-1:0]       u2_w;
  logic [vgw_pkg::U2_W-1:0]        u2_r, u3_u2_r;
  logic [vgw_pkg::U2_W+vgw_pkg::U_W-1:0] u3_w;
  logic [vgw_pkg::U3_W-1:0]        u3_r;
  logic [vgw_pkg::U3_W+vgw_pkg::D6_MUL_W-1:0] d6_w;
  logic [vgw_pkg::P_W-1:0]         p0_nxt;
  logic [vgw_pkg::P_W-1:0]         p_r   [0:vgw_pkg::SQ_STEPS];
  logic [vgw_pkg::P_W-1:0]         p_nxt [1:vgw_pkg::SQ_STEPS];
  logic [2*vgw_pkg::P_W-1:0]       sq_w  [1:vgw_pkg::SQ_STEPS];
  logic [vgw_pkg::P_W-1:0]         base;
  logic [vgw_pkg::Q_W-1:0]         q_nxt, q_r;

  always_comb begin
    ai = a_in[vgw_pkg::EXP_IN_W-1:vgw_pkg::FRAC];
    af = a_in[vgw_pkg::FRAC-1:0];
    fr = ~af + vgw_pkg::FRAC'(1);
    fprod = fr * vgw_pkg::LN2_Q30;
    ctrl_nxt.use_one = (af == '0);
    ctrl_nxt.kill = ctrl_nxt.use_one ? (ai > vgw_pkg::AI_W'(vgw_pkg::FRAC))
                                     : (ai >= vgw_pkg::AI_W'(vgw_pkg::EXP_KILL_AI));
    ctrl_nxt.sh = ctrl_nxt.use_one ? vgw_pkg::SH_W'(ai)
                                   : vgw_pkg::SH_W'(ai + vgw_pkg::AI_W'(1));
    u2_w = u1_r * u1_r;
    u3_w = u2_r * u2_u_r;
    d6_w = u3_r * vgw_pkg::DIV6_MUL;
    p0_nxt = vgw_pkg::P_W'(vgw_pkg::ONE_Q) + vgw_pkg::P_W'(u3_u_r)
           + vgw_pkg::P_W'(u3_u2_r >> 1)
           + vgw_pkg::P_W'(d6_w[vgw_pkg::U3_W+vgw_pkg::D6_MUL_W-1:vgw_pkg::D6_SHIFT]);
    for (int i = 1; i <= vgw_pkg::SQ_STEPS; i++) begin
      sq_w[i] = (2*vgw_pkg::P_W)'(p_r[i-1]) * (2*vgw_pkg::P_W)'(p_r[i-1])
              + ((2*vgw_pkg::P_W)'(1) << (vgw_pkg::FRAC - 1));
      p_nxt[i] = sq_w[i][vgw_pkg::FRAC +: vgw_pkg::P_W];
    end
    base = ctrl_r[vgw_pkg::EXP_LAT-2].use_one ? vgw_pkg::P_W'(vgw_pkg::ONE_Q)
                                              : p_r[vgw_pkg::SQ_STEPS];
    q_nxt = ctrl_r[vgw_pkg::EXP_LAT-2].kill ? '0
          : vgw_pkg::Q_W'(base >> ctrl_r[vgw_pkg::EXP_LAT-2].sh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r[0] <= ctrl_nxt;
      for (int i = 1; i < vgw_pkg::EXP_LAT - 1; i++) ctrl_r[i] <= ctrl_r[i-1];
      u1_r <= fprod[2*vgw_pkg::FRAC-1 -: vgw_pkg::U_W];
      u2_u_r <= u1_r;
      u2_r <= u2_w[2*vgw_pkg::U_W-1:vgw_pkg::FRAC];
      u3_u_r <= u2_u_r;
      u3_u2_r <= u2_r;
      u3_r <= u3_w[vgw_pkg::U2_W+vgw_pkg::U_W-1:vgw_pkg::FRAC];
      p_r[0] <= p0_nxt;
      for (int i = 1; i <= vgw_pkg::SQ_STEPS; i++) p_r[i] <= p_nxt[i];
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

`default_nettype wire

FILE: rtl/van_genuchten_water_content_unit.sv
// van Genuchten water content unit: pressure head in, Q0.16 water content out.
// Throughput one item per cycle while in_stall is low.
// Stages: three log2 units (one result bit per stage), two exp2 units, mix and round.
// An output register plus a skid stage keep input open while one result waits; a second one raises in_stall.
// rst_n is synchronous: clears valid bits and skid state, loads the config registers with their defaults.
// Depends on vgw_pkg, vgw_log2, vgw_exp2neg and the assert macro header.
`default_nettype none
`include "van_genuchten_water_content_unit_assert.svh"

module van_genuchten_water_content_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [vgw_pkg::HEAD_BITS-1:0]   in_pressure_head,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [vgw_pkg::CONT_W-1:0]      out_water_content,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vgw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vgw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [vgw_pkg::ALPHA_W-1:0] alpha_r;
  logic [vgw_pkg::N_W-1:0]     shape_n_r;
  logic [vgw_pkg::M_W-1:0]     shape_m_r;
  logic [vgw_pkg::CONT_W-1:0]  sat_r, res_r;

  logic                          en;
  logic [vgw_pkg::PIPE_LAT-1:0]  vld_r;
  logic                          out_valid_r, skid_valid_r;
  logic [vgw_pkg::CONT_W-1:0]    out_wc_r, skid_wc_r;

  logic [vgw_pkg::HEAD_BITS-1:0] head_r;
  logic [vgw_pkg::HEAD_BITS-1:0] mag;
  logic                          byp_nxt;
  logic                          byp_r [0:vgw_pkg::BYP_LEN-1];
  logic [vgw_pkg::LOG_RES_W-1:0] la, lm, lt;

  logic [vgw_pkg::LX_W-1:0]      lx;
  logic [vgw_pkg::AL_W-1:0]      al_r;
  logic                          lneg_a_r, lneg_b_r, lneg_c_r;
  logic [vgw_pkg::N_W+vgw_pkg::AL_LO_W-1:0] npl_r;
  logic [vgw_pkg::N_W+vgw_pkg::AL_HI_W-1:0] nph_r;
  logic [vgw_pkg::N_W+vgw_pkg::AL_W:0]      ay_sum;
  logic [vgw_pkg::AY_W-1:0]      ay_r;
  logic [vgw_pkg::AY_W-1:0]      ay_dly_r   [0:vgw_pkg::AY_LEN-1];
  logic                          lneg_dly_r [0:vgw_pkg::AY_LEN-1];

  logic [vgw_pkg::Q_W-1:0]       w1, f2;
  logic [vgw_pkg::LOG_IN_W-1:0]  one_plus_w;
  logic [vgw_pkg::T_W-1:0]       t_nxt, t_r;
  logic [vgw_pkg::M_W+vgw_pkg::T_LO_W-1:0] mpl_r;
  logic [vgw_pkg::M_W+vgw_pkg::T_HI_W-1:0] mph_r;
  logic [vgw_pkg::M_W+vgw_pkg::T_W:0]      e_sum;
  logic [vgw_pkg::E_W-1:0]       e_r;

  logic [vgw_pkg::Q_W-1:0]       f_sel;
  logic [vgw_pkg::MIX_W-1:0]     mix_res_r, mix_sat_r;
  logic [vgw_pkg::MIX_W:0]       mix_sum;
  logic [vgw_pkg::MIX_W-vgw_pkg::FRAC:0] wc_round;
  logic [vgw_pkg::CONT_W-1:0]    wc_nxt, wc_r;

  assign en = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_water_content = out_wc_r;

  assign mag = ~head_r + vgw_pkg::HEAD_BITS'(1);
  assign byp_nxt = !head_r[vgw_pkg::HEAD_BITS-1] || (alpha_r == '0);

  vgw_log2 u_log_alpha (
    .clk     (clk),
    .en      (en),
    .v_in    (vgw_pkg::LOG_IN_W'(alpha_r)),
    .res_out (la)
  );

  vgw_log2 u_log_head (
    .clk     (clk),
    .en      (en),
    .v_in    (vgw_pkg::LOG_IN_W'(mag)),
    .res_out (lm)
  );

  assign lx = vgw_pkg::LX_W'(la) + vgw_pkg::LX_W'(lm) - vgw_pkg::LX_OFS;
  assign ay_sum = ((vgw_pkg::N_W+vgw_pkg::AL_W+1)'(nph_r) << vgw_pkg::AL_LO_W)
                + (vgw_pkg::N_W+vgw_pkg::AL_W+1)'(npl_r)
                + ((vgw_pkg::N_W+vgw_pkg::AL_W+1)'(1) << (vgw_pkg::RND_W - 1));

  vgw_exp2neg u_exp_y (
    .clk   (clk),
    .en    (en),
    .a_in  (vgw_pkg::EXP_IN_W'(ay_r)),
    .q_out (w1)
  );

  assign one_plus_w = vgw_pkg::LOG_IN_W'(vgw_pkg::ONE_Q) + vgw_pkg::LOG_IN_W'(w1);

  vgw_log2 u_log_sum (
    .clk     (clk),
    .en      (en),
    .v_in    (one_plus_w),
    .res_out (lt)
  );

  assign t_nxt = vgw_pkg::T_W'(lt - vgw_pkg::LOG_OFS)
               + (lneg_dly_r[vgw_pkg::AY_LEN-1] ? '0
                  : vgw_pkg::T_W'(ay_dly_r[vgw_pkg::AY_LEN-1]));
  assign e_sum = ((vgw_pkg::M_W+vgw_pkg::T_W+1)'(mph_r) << vgw_pkg::T_LO_W)
               + (vgw_pkg::M_W+vgw_pkg::T_W+1)'(mpl_r)
               + ((vgw_pkg::M_W+vgw_pkg::T_W+1)'(1) << (vgw_pkg::RND_W - 1));

  vgw_exp2neg u_exp_e (
    .clk   (clk),
    .en    (en),
    .a_in  (e_r),
    .q_out (f2)
  );

  assign f_sel = byp_r[vgw_pkg::BYP_LEN-1] ? vgw_pkg::ONE_Q : f2;
  assign mix_sum = (vgw_pkg::MIX_W+1)'(mix_res_r) + (vgw_pkg::MIX_W+1)'(mix_sat_r)
                 + ((vgw_pkg::MIX_W+1)'(1) << (vgw_pkg::FRAC - 1));
  assign wc_round = mix_sum[vgw_pkg::MIX_W:vgw_pkg::FRAC];
  assign wc_nxt = (wc_round > (vgw_pkg::MIX_W-vgw_pkg::FRAC+1)'(vgw_pkg::WC_MAX))
                ? vgw_pkg::WC_MAX : wc_round[vgw_pkg::CONT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= vgw_pkg::ALPHA_RST;
      shape_n_r <= vgw_pkg::N_RST;
      shape_m_r <= vgw_pkg::M_RST;
      sat_r <= vgw_pkg::SAT_RST;
      res_r <= vgw_pkg::RES_RST;
      vld_r <= '0;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (vgw_pkg::cfg_idx_t'(cfg_index))
          vgw_pkg::CFG_ALPHA:   alpha_r <= cfg_data[vgw_pkg::ALPHA_W-1:0];
          vgw_pkg::CFG_SHAPE_N: shape_n_r <= cfg_data[vgw_pkg::N_W-1:0];
          vgw_pkg::CFG_SHAPE_M: shape_m_r <= cfg_data[vgw_pkg::M_W-1:0];
          vgw_pkg::CFG_SAT:     sat_r <= cfg_data[vgw_pkg::CONT_W-1:0];
          vgw_pkg::CFG_RES:     res_r <= cfg_data[vgw_pkg::CONT_W-1:0];
          default: begin
          end
        endcase
      end
      if (en) vld_r <= {vld_r[vgw_pkg::PIPE_LAT-2:0], in_valid};
      if (skid_valid_r) begin
        if (!out_stall) skid_valid_r <= 1'b0;
      end else if (!out_valid_r || !out_stall) begin
        out_valid_r <= vld_r[vgw_pkg::PIPE_LAT-1];
      end else if (vld_r[vgw_pkg::PIPE_LAT-1]) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= in_pressure_head;
      byp_r[0] <= byp_nxt;
      for (int i = 1; i < vgw_pkg::BYP_LEN; i++) byp_r[i] <= byp_r[i-1];
      lneg_a_r <= lx[vgw_pkg::LX_W-1];
      al_r <= lx[vgw_pkg::LX_W-1] ? vgw_pkg::AL_W'(-lx) : vgw_pkg::AL_W'(lx);
      npl_r <= shape_n_r * al_r[vgw_pkg::AL_LO_W-1:0];
      nph_r <= shape_n_r * al_r[vgw_pkg::AL_W-1:vgw_pkg::AL_LO_W];
      lneg_b_r <= lneg_a_r;
      ay_r <= ay_sum[vgw_pkg::RND_W +: vgw_pkg::AY_W];
      lneg_c_r <= lneg_b_r;
      ay_dly_r[0] <= ay_r;
      lneg_dly_r[0] <= lneg_c_r;
      for (int i = 1; i < vgw_pkg::AY_LEN; i++) begin
        ay_dly_r[i] <= ay_dly_r[i-1];
        lneg_dly_r[i] <= lneg_dly_r[i-1];
      end
      t_r <= t_nxt;
      mpl_r <= shape_m_r * t_r[vgw_pkg::T_LO_W-1:0];
      mph_r <= shape_m_r * t_r[vgw_pkg::T_W-1:vgw_pkg::T_LO_W];
      e_r <= e_sum[vgw_pkg::RND_W +: vgw_pkg::E_W];
      mix_res_r <= res_r * (vgw_pkg::ONE_Q - f_sel);
      mix_sat_r <= sat_r * f_sel;
      wc_r <= wc_nxt;
    end
    if (skid_valid_r) begin
      if (!out_stall) out_wc_r <= skid_wc_r;
    end else if (!out_valid_r || !out_stall) begin
      out_wc_r <= wc_r;
    end else begin
      skid_wc_r <= wc_r;
    end
  end

  `VGW_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_r[0])
  `VGW_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r)
  `VGW_ASSERT_NEXT(a_skid_holds, skid_valid_r && out_stall, skid_valid_r && out_valid_r)

endmodule

`default_nettype wire

FILE: tb/van_genuchten_water_content_unit_test.sv
// Testbench for the van Genuchten water content unit: pressure heads in, Q0.16 water
// content out, compared against a bit-exact log2/exp2 predictor held in a scoreboard.
// Depends on vgw_pkg and the unit's RTL.
`timescale 1ns / 1ps

module van_genuchten_water_content_unit_test;

  class content_scoreboard;
    logic [23:0] alpha;
    logic [19:0] shape_n;
    logic [16:0] shape_m;
    logic [15:0] sat;
    logic [15:0] resid;
    logic [15:0] pending[$];
    int errors;

    function new();
      errors = 0;
      set_defaults();
    endfunction

    function void set_defaults();
      alpha = vgw_pkg::ALPHA_RST;
      shape_n = vgw_pkg::N_RST;
      shape_m = vgw_pkg::M_RST;
      sat = vgw_pkg::SAT_RST;
      resid = vgw_pkg::RES_RST;
    endfunction

    function void write_reg(vgw_pkg::cfg_idx_t idx, logic [23:0] value);
      case (idx)
        vgw_pkg::CFG_ALPHA: alpha = value;
        vgw_pkg::CFG_SHAPE_N: shape_n = value[19:0];
        vgw_pkg::CFG_SHAPE_M: shape_m = value[16:0];
        vgw_pkg::CFG_SAT: sat = value[15:0];
        vgw_pkg::CFG_RES: resid = value[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned log2_q30(longint unsigned v);
      longint unsigned t, mant, res;
      int k;
      if (v == 0) return 0;
      k = 0;
      t = v;
      while (t > 1) begin
        t >>= 1;
        k++;
      end
      mant = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
      res = longint'(k) << 30;
      for (int i = 29; i >= 0; i--) begin
        mant = (mant * mant) >> 30;
        if (mant >= (64'd2 << 30)) begin
          mant >>= 1;
          res |= 64'd1 << i;
        end
      end
      return res;
    endfunction

    function longint unsigned pow2_frac(longint unsigned f);
      longint unsigned u, u2, u3, p;
      u = ((f & 64'h3FFF_FFFF) * 64'd744261118) >> 38;
      u2 = (u * u) >> 30;
      u3 = (u2 * u) >> 30;
      p = (64'd1 << 30) + u + u2 / 2 + u3 / 6;
      for (int i = 0; i < 8; i++) p = (p * p + (64'd1 << 29)) >> 30;
      return p;
    endfunction

    function longint unsigned pow2_neg(longint unsigned a);
      longint unsigned ai, af;
      ai = a >> 30;
      af = a & 64'h3FFF_FFFF;
      if (af == 0) return (ai > 30) ? 0 : ((64'd1 << 30) >> ai);
      if (ai + 1 >= 62) return 0;
      return pow2_frac((64'd1 << 30) - af) >> (ai + 1);
    endfunction

    function logic [15:0] water_content(logic [31:0] head);
      longint unsigned f, mag, al, ay, w, t, e, total, res;
      longint lx;
      if (!head[31] || alpha == 0) begin
        f = 64'd1 << 30;
      end else begin
        mag = (64'd1 << 32) - head;
        lx = longint'(log2_q30(alpha)) + longint'(log2_q30(mag)) - (64'sd32 <<< 30);
        al = (lx < 0) ? -lx : lx;
        ay = (shape_n * al + 32768) >> 16;
        w = pow2_neg(ay);
        t = log2_q30((64'd1 << 30) + w) - (64'd30 << 30);
        if (lx >= 0) t += ay;
        e = (shape_m * t + 32768) >> 16;
        f = pow2_neg(e);
      end
      total = resid * ((64'd1 << 30) - f) + sat * f;
      res = (total + (64'd1 << 29)) >> 30;
      if (res > 65535) res = 65535;
      return res[15:0];
    endfunction

    function void note_head(logic [31:0] head);
      pending = {pending, water_content(head)};
    endfunction

    function void check_content(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected water_content %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: water_content expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] in_pressure_head = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_water_content;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  content_scoreboard board = new();
  int idle_cycles = 0;
  bit stall_burst = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  van_genuchten_water_content_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pressure_head(in_pressure_head),
    .out_valid(out_valid), .out_stall(out_stall), .out_water_content(out_water_content),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // check results, vary the receiver stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_content(out_water_content);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if ($urandom_range(0, 63) == 0) stall_burst <= ~stall_burst;
      out_stall <= stall_burst ? ($urandom_range(0, 3) != 0) : 1'b0;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(vgw_pkg::cfg_idx_t idx, logic [23:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    cfg_valid <= 0;
  endtask

  task automatic send_head(logic [31:0] head);
    in_valid <= 1;
    in_pressure_head <= head;
    do @(posedge clk); while (in_stall);
    board.note_head(head);
  endtask

  task automatic pause(int cycles);
    in_valid <= 0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] random_head();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return -$urandom_range(1, 1 << 16);
      2: return -$urandom_range(1, 1 << 24);
      3: return $urandom() | 32'h8000_0000;
      4: return $urandom_range(0, 1 << 20);
      default: return -($urandom() >> $urandom_range(0, 31));
    endcase
  endfunction

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++, count--) send_head(random_head());
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
    end
    drain();
  endtask

  logic [31:0] corner_heads [0:11] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
    32'hFFFF_0000, 32'hFFFE_0000, 32'h0001_0000, 32'hF000_0000, 32'hFFFF_8000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hFF00_0000};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (corner_heads[i]) send_head(corner_heads[i]);
    drain();
    // zero alpha, zero n, zero m, residual above saturated, largest settings
    write_reg(vgw_pkg::CFG_ALPHA, 24'd0);
    write_reg(vgw_pkg::CFG_SHAPE_N, 24'd0);
    write_reg(vgw_pkg::CFG_SHAPE_M, 24'd0);
    write_reg(vgw_pkg::CFG_SAT, 24'd1000);
    write_reg(vgw_pkg::CFG_RES, 24'd60000);
    foreach (corner_heads[i]) send_head(corner_heads[i]);
    drain();
    write_reg(vgw_pkg::CFG_ALPHA, 24'hFF_FFFF);
    write_reg(vgw_pkg::CFG_SHAPE_M, 24'd32768);
    foreach (corner_heads[i]) send_head(corner_heads[i]);
    drain();
    write_reg(vgw_pkg::CFG_SHAPE_N, 24'hF_FFFF);
    write_reg(vgw_pkg::CFG_SHAPE_M, 24'h1_FFFF);
    write_reg(vgw_pkg::CFG_SAT, 24'hFFFF);
    write_reg(vgw_pkg::CFG_RES, 24'hFFFF);
    random_phase(200);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(vgw_pkg::CFG_ALPHA, (ph % 3 == 0) ? 24'($urandom_range(0, 24'hFF_FFFF))
                                                  : 24'($urandom_range(1 << 12, 1 << 20)));
      write_reg(vgw_pkg::CFG_SHAPE_N, 24'($urandom_range(65536, 20'hF_FFFF)));
      write_reg(vgw_pkg::CFG_SHAPE_M, 24'($urandom_range(0, 65536)));
      write_reg(vgw_pkg::CFG_SAT, 24'($urandom_range(0, 65535)));
      write_reg(vgw_pkg::CFG_RES, (ph == 5) ? 24'hFFFF : 24'($urandom_range(0, 30000)));
      random_phase(200);
    end
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/vgw_pkg.sv
rtl/vgw_log2.sv
rtl/vgw_exp2neg.sv
rtl/van_genuchten_water_content_unit.sv
tb/van_genuchten_water_content_unit_test.sv
